// ----- src/dlg_pkg.sv -----
// ----------------------------------------------------------------------------
// dlg_pkg
// Shared types, constants and lookup tables for the dithered luma to glyph
// pipeline.
// ----------------------------------------------------------------------------
package dlg_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_WINDOW_LEFT     = 3'd0,
      CSR_WINDOW_TOP      = 3'd1,
      CSR_WINDOW_WIDTH    = 3'd2,
      CSR_WINDOW_HEIGHT   = 3'd3,
      CSR_DITHER_STRENGTH = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [15:0] STRENGTH_RESET = 16'd7864;

   // Brightness is floor(sum * 65536 / 765); the quotient is estimated with a
   // reciprocal of 2^32/765 and fixed up with one compare and subtract.
   localparam logic [9:0]  LUMA_DIV   = 10'd765;
   localparam logic [22:0] LUMA_RECIP = 23'd5614336;
   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [6:0]  BAYER_MID  = 7'd63;

   localparam logic [4:0] RAMP_LAST  = 5'd9;
   localparam logic [4:0] HEAVY_LAST = 5'd19;

   // 8x8 ordered dither matrix, row major, indexed by {row[2:0], col[2:0]}
   localparam logic [5:0] BAYER_TAB [64] = '{
      6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
      6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
      6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
      6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
      6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
      6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
      6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
      6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
   };

   // Glyph ramp " .:-=+*#%@"
   localparam logic [6:0] RAMP_TAB [10] = '{
      7'd32, 7'd46, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd35, 7'd37, 7'd64
   };

   typedef struct packed {
      logic [7:0]  window_left;
      logic [6:0]  window_top;
      logic [7:0]  window_width;
      logic [6:0]  window_height;
      logic [15:0] dither_strength;
   } cfg_type;

   // After window test and dither matrix lookup
   typedef struct packed {
      logic       in_window;
      logic [9:0] sum;
      logic [5:0] dmag;
      logic       neg;
   } prep_type;

   // After the two multiplies
   typedef struct packed {
      logic        in_window;
      logic [9:0]  sum;
      logic [16:0] qe;
      logic [14:0] mag;
      logic        neg;
   } quot_type;

   // Exact brightness with pending dither offset
   typedef struct packed {
      logic [16:0] q;
      logic [14:0] mag;
      logic        neg;
   } bright_type;

   typedef struct packed {
      logic [6:0] normal_glyph;
      logic [6:0] invert_glyph;
      logic [6:0] heavy_glyph;
   } glyph_type;

endpackage

// ----- src/dlg_prep.sv -----
// ----------------------------------------------------------------------------
// dlg_prep
// Window test, channel sum and dither matrix lookup, then the reciprocal
// multiply for brightness and the dither gain multiply. Two stages.
// ----------------------------------------------------------------------------
module dlg_prep
   import dlg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [6:0] in_col,
   input  logic [5:0] in_row,
   input  logic [7:0] in_red,
   input  logic [7:0] in_green,
   input  logic [7:0] in_blue,
   output logic       out_valid,
   input  logic       out_ready,
   output quot_type   out_data
);

   logic     a_valid_ff, a_valid_in;
   prep_type a_ff, a_in;
   logic     b_valid_ff, b_valid_in;
   quot_type b_ff, b_in;

   logic a_ready, b_ready;

   logic [8:0] col_end;
   logic [7:0] row_end;
   logic       col_ok, row_ok;
   logic [5:0] m;
   logic [6:0] m2;
   prep_type   a_new;
   quot_type   b_new;
   logic [32:0] prod_q;
   logic [21:0] prod_d;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Stage A
   always_comb begin
      col_end = {1'b0, cfg.window_left} + {1'b0, cfg.window_width};
      row_end = {1'b0, cfg.window_top} + {1'b0, cfg.window_height};
      col_ok  = ({1'b0, in_col} >= cfg.window_left) &&
                ({2'b00, in_col} < col_end);
      row_ok  = ({1'b0, in_row} >= cfg.window_top) &&
                ({2'b00, in_row} < row_end);
      m       = BAYER_TAB[{in_row[2:0], in_col[2:0]}];
      m2      = {m, 1'b0};

      a_new.in_window = col_ok && row_ok;
      a_new.sum       = {2'b00, in_red} + {2'b00, in_green} + {2'b00, in_blue};
      a_new.neg       = m2 < BAYER_MID;
      a_new.dmag      = a_new.neg ? 6'(BAYER_MID - m2) : 6'(m2 - BAYER_MID);

      a_valid_in = a_ready ? in_valid : a_valid_ff;
      a_in       = (a_ready && in_valid) ? a_new : a_ff;
   end

   // Stage B
   always_comb begin
      prod_q = 33'(a_ff.sum) * 33'(LUMA_RECIP);
      prod_d = 22'(a_ff.dmag) * 22'(cfg.dither_strength);

      b_new.in_window = a_ff.in_window;
      b_new.sum       = a_ff.sum;
      b_new.qe        = prod_q[32:16];
      b_new.mag       = prod_d[21:7];
      b_new.neg       = a_ff.neg;

      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      b_in       = (b_ready && a_valid_ff) ? b_new : b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_ff;

endmodule

// ----- src/dlg_luma.sv -----
// ----------------------------------------------------------------------------
// dlg_luma
// Quotient fix-up for the brightness divide, letterbox override, then dither
// offset and clamp to [0, 1.0]. Two stages.
// ----------------------------------------------------------------------------
module dlg_luma
   import dlg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  quot_type    in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [16:0] out_bright
);

   logic        c_valid_ff, c_valid_in;
   bright_type  c_ff, c_in;
   logic        d_valid_ff, d_valid_in;
   logic [16:0] d_ff, d_in;

   logic c_ready, d_ready;

   logic [26:0] num, back, rem;
   logic [16:0] q_fix;
   bright_type  c_new;
   logic signed [18:0] sq, smag, sumv;
   logic [16:0] d_new;

   assign d_ready  = !d_valid_ff || out_ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   // Stage C: estimate is exact or one short
   always_comb begin
      num   = {1'b0, in_data.sum, 16'd0};
      back  = 27'(in_data.qe) * 27'(LUMA_DIV);
      rem   = num - back;
      q_fix = in_data.qe + 17'(rem >= 27'(LUMA_DIV));

      c_new.q   = in_data.in_window ? q_fix : ONE_Q16;
      c_new.mag = in_data.mag;
      c_new.neg = in_data.neg;

      c_valid_in = c_ready ? in_valid : c_valid_ff;
      c_in       = (c_ready && in_valid) ? c_new : c_ff;
   end

   // Stage D
   always_comb begin
      sq   = $signed({2'b00, c_ff.q});
      smag = $signed({4'h0, c_ff.mag});
      sumv = c_ff.neg ? (sq - smag) : (sq + smag);
      if (sumv < 0) begin
         d_new = 17'd0;
      end else if (sumv > $signed({2'b00, ONE_Q16})) begin
         d_new = ONE_Q16;
      end else begin
         d_new = sumv[16:0];
      end

      d_valid_in = d_ready ? c_valid_ff : d_valid_ff;
      d_in       = (d_ready && c_valid_ff) ? d_new : d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
      c_ff <= c_in;
      d_ff <= d_in;
   end

   assign out_valid  = d_valid_ff;
   assign out_bright = d_ff;

endmodule

// ----- src/dlg_glyph.sv -----
// ----------------------------------------------------------------------------
// dlg_glyph
// Ramp index computation and glyph lookup into the output register.
// ----------------------------------------------------------------------------
module dlg_glyph
   import dlg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [16:0] in_bright,
   output logic        out_valid,
   input  logic        out_ready,
   output glyph_type   out_data
);

   logic      e_valid_ff, e_valid_in;
   glyph_type e_ff, e_in;

   logic [16:0] inv;
   logic [21:0] p_norm, p_inv, p_heavy;
   logic [4:0]  ni, ii, hi;
   glyph_type   e_new;

   assign in_ready = !e_valid_ff || out_ready;

   always_comb begin
      inv     = ONE_Q16 - in_bright;
      p_norm  = 22'(in_bright) * 22'(9);
      p_inv   = 22'(inv) * 22'(9);
      p_heavy = 22'(in_bright) * 22'(19);

      ni = (p_norm[20:16]  > RAMP_LAST)  ? RAMP_LAST  : p_norm[20:16];
      ii = (p_inv[20:16]   > RAMP_LAST)  ? RAMP_LAST  : p_inv[20:16];
      hi = (p_heavy[20:16] > HEAVY_LAST) ? HEAVY_LAST : p_heavy[20:16];

      e_new.normal_glyph = RAMP_TAB[ni[3:0]];
      e_new.invert_glyph = RAMP_TAB[ii[3:0]];
      e_new.heavy_glyph  = RAMP_TAB[hi[4:1]];

      e_valid_in = in_ready ? in_valid : e_valid_ff;
      e_in       = (in_ready && in_valid) ? e_new : e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= e_valid_in;
      end
      e_ff <= e_in;
   end

   assign out_valid = e_valid_ff;
   assign out_data  = e_ff;

endmodule

// ----- src/dithered_luma_to_glyph_unit.sv -----
// ----------------------------------------------------------------------------
// dithered_luma_to_glyph_unit
// Ordered-dither brightness to glyph mapper: one grid cell in, three glyph
// codes out.
// ----------------------------------------------------------------------------
// Pipeline: five register stages (lookup, multiply, divide fix-up, dither
//    clamp, ramp); empty stages fill under rsp_stall.
// Throughput: one transaction per cycle while req_stall is low.
// Reset: synchronous; clears all stage valid bits and loads the register
//    defaults (window at origin spanning the full grid, dither 7864).
// ----------------------------------------------------------------------------
module dithered_luma_to_glyph_unit
   import dlg_pkg::*;
#(
   parameter int GRID_COLUMNS = 128,
   parameter int GRID_ROWS    = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [6:0]             req_grid_col,
   input  logic [5:0]             req_grid_row,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [6:0]             rsp_normal_glyph,
   output logic [6:0]             rsp_invert_glyph,
   output logic [6:0]             rsp_heavy_glyph
);

   localparam logic [7:0] WIDTH_RESET  = 8'(GRID_COLUMNS % 256);
   localparam logic [6:0] HEIGHT_RESET = 7'(GRID_ROWS % 128);

   cfg_type cfg_ff, cfg_in;

   logic        prep_ready;
   logic        quot_valid, quot_ready;
   quot_type    quot_data;
   logic        bright_valid, bright_ready;
   logic [16:0] bright;
   glyph_type   glyph;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_LEFT:     cfg_in.window_left     = csr_wdata[7:0];
            CSR_WINDOW_TOP:      cfg_in.window_top      = csr_wdata[6:0];
            CSR_WINDOW_WIDTH:    cfg_in.window_width    = csr_wdata[7:0];
            CSR_WINDOW_HEIGHT:   cfg_in.window_height   = csr_wdata[6:0];
            CSR_DITHER_STRENGTH: cfg_in.dither_strength = csr_wdata;
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_left     <= 8'd0;
         cfg_ff.window_top      <= 7'd0;
         cfg_ff.window_width    <= WIDTH_RESET;
         cfg_ff.window_height   <= HEIGHT_RESET;
         cfg_ff.dither_strength <= STRENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlg_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .in_col    (req_grid_col),
      .in_row    (req_grid_row),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_data  (quot_data)
   );

   dlg_luma u_luma (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (quot_valid),
      .in_ready   (quot_ready),
      .in_data    (quot_data),
      .out_valid  (bright_valid),
      .out_ready  (bright_ready),
      .out_bright (bright)
   );

   dlg_glyph u_glyph (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (bright_valid),
      .in_ready  (bright_ready),
      .in_bright (bright),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (glyph)
   );

   assign req_stall        = !prep_ready;
   assign rsp_normal_glyph = glyph.normal_glyph;
   assign rsp_invert_glyph = glyph.invert_glyph;
   assign rsp_heavy_glyph  = glyph.heavy_glyph;

endmodule

// ----- src/dlg_checker.sv -----
// ----------------------------------------------------------------------------
// dlg_checker
// Port-level checks for the glyph unit, attached by bind.
// ----------------------------------------------------------------------------
module dlg_checker
   import dlg_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_normal_glyph,
   input logic [6:0] rsp_invert_glyph,
   input logic [6:0] rsp_heavy_glyph
);

   // No transaction right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // A stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_glyph) &&
      $stable(rsp_invert_glyph) && $stable(rsp_heavy_glyph))
      else $error("stalled response changed");

   // Normal glyph comes from the ramp
   a_normal_ramp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_glyph == 7'd32 || rsp_normal_glyph == 7'd46 ||
      rsp_normal_glyph == 7'd58 || rsp_normal_glyph == 7'd45 ||
      rsp_normal_glyph == 7'd61 || rsp_normal_glyph == 7'd43 ||
      rsp_normal_glyph == 7'd42 || rsp_normal_glyph == 7'd35 ||
      rsp_normal_glyph == 7'd37 || rsp_normal_glyph == 7'd64)
      else $error("normal glyph off ramp");

   // Full brightness: top of both ramps, bottom of the inverted ramp
   a_full_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_glyph == 7'd64 |->
      rsp_invert_glyph == 7'd32 && rsp_heavy_glyph == 7'd64)
      else $error("inconsistent glyphs at full brightness");

endmodule

bind dithered_luma_to_glyph_unit dlg_checker u_dlg_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_normal_glyph (rsp_normal_glyph),
   .rsp_invert_glyph (rsp_invert_glyph),
   .rsp_heavy_glyph  (rsp_heavy_glyph)
);
